@@ rtl/core/btec_pkg.sv @@
`timescale 1ns / 1ps
package btec_pkg;

  // Default sizes of the two cell rows.
  localparam int DefEntries = 16;
  localparam int DefPendingDepth = 16;

  // Most answers released by one fill.
  localparam int MaxResults = 16;
  localparam int ResCntW = $clog2(MaxResults + 1);

  // Result kinds.
  localparam logic [1:0] KIND_ANSWER = 2'd0;
  localparam logic [1:0] KIND_FETCH = 2'd1;
  localparam logic [1:0] KIND_OVERFLOW = 2'd2;

  // Input function codes.
  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_FILL = 1'b1;

  // Configuration register indexes.
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_LRU = 1'b1;

  // One cached bounds entry.
  typedef struct packed {
    logic [15:0] id;
    logic [31:0] base;
    logic [31:0] size;
    logic        ro;
  } entry_t;

  // One parked lookup request.
  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  tag;
    logic [31:0] addr;
    logic [31:0] uuid;
  } pend_t;

  // Per-cell control: load the broadcast word or take the right neighbor's word.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

@@ rtl/core/btec_entry_cell.sv @@
`timescale 1ns / 1ps
module btec_entry_cell (
  input  logic               clk,
  input  btec_pkg::cell_ctl_t ctl,
  input  btec_pkg::entry_t   right,
  input  btec_pkg::entry_t   load_data,
  input  logic [15:0]        key,
  output btec_pkg::entry_t   q,
  output logic               match
);
  import btec_pkg::*;

  // Hold one entry; load a new one or take the younger neighbor's entry.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= load_data;
    end else if (ctl.shift) begin
      q <= right;
    end
  end

  assign match = (q.id == key);
endmodule

@@ rtl/core/btec_pend_cell.sv @@
`timescale 1ns / 1ps
module btec_pend_cell (
  input  logic               clk,
  input  btec_pkg::cell_ctl_t ctl,
  input  btec_pkg::pend_t    right,
  input  btec_pkg::pend_t    load_data,
  input  logic [15:0]        key,
  output btec_pkg::pend_t    q,
  output logic               match
);
  import btec_pkg::*;

  // Hold one parked request; the row closes gaps by shifting toward the oldest.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= load_data;
    end else if (ctl.shift) begin
      q <= right;
    end
  end

  assign match = (q.id == key);
endmodule

@@ rtl/core/bounds_table_entry_cache_unit.sv @@
`timescale 1ns / 1ps
// A lookup compares the id in every entry cell at once and the oldest
// match answers, moving to the youngest place in LRU mode; a miss is parked in the
// pending row and sends a fetch unless an equal id is already parked, or gets an
// overflow result when the row is full. A fill evicts the oldest entries one at a time,
// appends the new entry, then releases matching parked requests one at a time (at most
// sixteen); when no parked request matches, it ends with no result.
// The pending row removes one request per cycle while the output register can take it.
// Results leave through a single output register; a new transaction is taken only
// when the sequencer is idle and that register is free or being emptied.
module bounds_table_entry_cache_unit #(
  parameter int ENTRIES = btec_pkg::DefEntries,
  parameter int PENDING_DEPTH = btec_pkg::DefPendingDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [15:0] buf_id,
  input  logic [7:0]  req_tag,
  input  logic [31:0] acc_addr,
  input  logic [31:0] req_uuid,
  input  logic [31:0] fill_base,
  input  logic [31:0] fill_size,
  input  logic        fill_ro,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [7:0]  out_tag,
  output logic [31:0] out_addr,
  output logic [31:0] out_uuid,
  output logic [15:0] out_buf_id,
  output logic [31:0] entry_base,
  output logic [31:0] entry_size,
  output logic        entry_ro,
  output logic        last
);
  import btec_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int PW = $clog2(PENDING_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVICT = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0] state, state_next;
  logic [4:0] cache_capacity;
  logic       lru_enable;
  logic [CW-1:0] entry_count, entry_count_next;
  logic [PW-1:0] pend_count, pend_count_next;
  logic [ResCntW-1:0] res_count, res_count_next;
  entry_t fill_entry;

  entry_t    eq [ENTRIES];
  logic [ENTRIES-1:0] ematch_raw, em, elow, ege;
  cell_ctl_t ectl [ENTRIES];
  entry_t    eload;
  entry_t    hit_data;

  pend_t     pq [PENDING_DEPTH];
  logic [PENDING_DEPTH-1:0] pmatch_raw, pm, plow, pge;
  cell_ctl_t pctl [PENDING_DEPTH];
  pend_t     pload;
  pend_t     pend_data;
  logic [15:0] pkey;

  logic [CW-1:0] cap_eff;
  logic oslot, accept, emit;
  logic [1:0] kind_next;
  logic [7:0] tag_next;
  logic [31:0] addr_next, uuid_next;
  entry_t ent_next;
  logic last_next;

  // Effective capacity: zero counts as one, large values clamp to the row size.
  always_comb begin
    if (cache_capacity == 5'd0) begin
      cap_eff = CW'(1);
    end else if (32'(cache_capacity) > 32'(ENTRIES)) begin
      cap_eff = CW'(ENTRIES);
    end else begin
      cap_eff = CW'(cache_capacity);
    end
  end

  // Entry row.
  for (genvar j = 0; j < ENTRIES; j++) begin : g_entry
    btec_entry_cell u_cell (
      .clk(clk), .ctl(ectl[j]), .right(eq[(j + 1 < ENTRIES) ? j + 1 : j]),
      .load_data(eload), .key(buf_id), .q(eq[j]), .match(ematch_raw[j])
    );
    assign em[j] = ematch_raw[j] && (j < int'(entry_count));
  end

  // Pending row.
  assign pkey = (state == ST_DRAIN) ? fill_entry.id : buf_id;
  for (genvar j = 0; j < PENDING_DEPTH; j++) begin : g_pend
    btec_pend_cell u_cell (
      .clk(clk), .ctl(pctl[j]), .right(pq[(j + 1 < PENDING_DEPTH) ? j + 1 : j]),
      .load_data(pload), .key(pkey), .q(pq[j]), .match(pmatch_raw[j])
    );
    assign pm[j] = pmatch_raw[j] && (j < int'(pend_count));
  end

  // Oldest match in each row and the cells at or above it.
  assign elow = em & (~em + ENTRIES'(1));
  assign ege = ~(elow - ENTRIES'(1));
  assign plow = pm & (~pm + PENDING_DEPTH'(1));
  assign pge = ~(plow - PENDING_DEPTH'(1));

  always_comb begin
    hit_data = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      if (elow[j]) hit_data = hit_data | eq[j];
    end
    pend_data = '0;
    for (int j = 0; j < PENDING_DEPTH; j++) begin
      if (plow[j]) pend_data = pend_data | pq[j];
    end
  end

  assign oslot = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && oslot;
  assign accept = in_valid && in_ready;

  // Sequencer: row controls, counters and the next result.
  always_comb begin
    state_next = state;
    entry_count_next = entry_count;
    pend_count_next = pend_count;
    res_count_next = res_count;
    eload = fill_entry;
    pload = '{id: buf_id, tag: req_tag, addr: acc_addr, uuid: req_uuid};
    for (int j = 0; j < ENTRIES; j++) ectl[j] = '0;
    for (int j = 0; j < PENDING_DEPTH; j++) pctl[j] = '0;
    emit = 1'b0;
    kind_next = KIND_ANSWER;
    tag_next = req_tag;
    addr_next = acc_addr;
    uuid_next = req_uuid;
    ent_next = '{id: buf_id, base: 32'd0, size: 32'd0, ro: 1'b0};
    last_next = 1'b1;
    case (state)
      ST_IDLE: begin
        if (accept && func == FUNC_FILL) begin
          state_next = ST_EVICT;
        end else if (accept) begin
          if (|em) begin
            emit = 1'b1;
            ent_next = hit_data;
            ent_next.id = buf_id;
            eload = hit_data;
            if (lru_enable) begin
              for (int j = 0; j < ENTRIES; j++) begin
                ectl[j].shift = ege[j] && (int'(entry_count) > j + 1);
                ectl[j].load = (int'(entry_count) == j + 1);
              end
            end
          end else if (int'(pend_count) == PENDING_DEPTH) begin
            emit = 1'b1;
            kind_next = KIND_OVERFLOW;
          end else begin
            for (int j = 0; j < PENDING_DEPTH; j++) begin
              pctl[j].load = (int'(pend_count) == j);
            end
            pend_count_next = pend_count + PW'(1);
            if (!(|pm)) begin
              emit = 1'b1;
              kind_next = KIND_FETCH;
            end
          end
        end
      end
      ST_EVICT: begin
        if (entry_count >= cap_eff) begin
          for (int j = 0; j < ENTRIES; j++) ectl[j].shift = 1'b1;
          entry_count_next = entry_count - CW'(1);
        end else begin
          for (int j = 0; j < ENTRIES; j++) begin
            ectl[j].load = (int'(entry_count) == j);
          end
          entry_count_next = entry_count + CW'(1);
          res_count_next = '0;
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!(|pm)) begin
          state_next = ST_IDLE;
        end else if (oslot) begin
          emit = 1'b1;
          tag_next = pend_data.tag;
          addr_next = pend_data.addr;
          uuid_next = pend_data.uuid;
          ent_next = fill_entry;
          last_next = ((pm & (pm - PENDING_DEPTH'(1))) == '0) ||
                      (int'(res_count) == MaxResults - 1);
          for (int j = 0; j < PENDING_DEPTH; j++) begin
            pctl[j].shift = pge[j] && (int'(pend_count) > j + 1);
          end
          pend_count_next = pend_count - PW'(1);
          res_count_next = res_count + ResCntW'(1);
          if (last_next) state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      entry_count <= '0;
      pend_count <= '0;
      res_count <= '0;
      out_valid <= 1'b0;
      cache_capacity <= 5'd16;
      lru_enable <= 1'b0;
    end else begin
      state <= state_next;
      entry_count <= entry_count_next;
      pend_count <= pend_count_next;
      res_count <= res_count_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we && cfg_index == REG_CAPACITY) cache_capacity <= cfg_data;
      if (cfg_we && cfg_index == REG_LRU) lru_enable <= cfg_data[0];
    end
  end

  // Payload registers: the fill being processed and the output slot.
  always_ff @(posedge clk) begin
    if (accept && func == FUNC_FILL) begin
      fill_entry <= '{id: buf_id, base: fill_base, size: fill_size, ro: fill_ro};
    end
    if (emit) begin
      result_kind <= kind_next;
      out_tag <= tag_next;
      out_addr <= addr_next;
      out_uuid <= uuid_next;
      out_buf_id <= ent_next.id;
      entry_base <= ent_next.base;
      entry_size <= ent_next.size;
      entry_ro <= ent_next.ro;
      last <= last_next;
    end
  end

  // The cache row never holds more entries than it has cells.
  a_entry_bound: assert property (@(posedge clk) disable iff (rst)
    int'(entry_count) <= ENTRIES) else $error("entry count exceeds row");

  // The pending row never holds more requests than it has cells.
  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    int'(pend_count) <= PENDING_DEPTH) else $error("pending count exceeds row");

  // A fill always passes through the eviction step before releasing requests.
  a_fill_seq: assert property (@(posedge clk) disable iff (rst)
    (accept && func == FUNC_FILL) |=> (state == ST_EVICT)) else $error("fill sequencing");

  // No new transaction is taken while a fill is in progress.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready) else $error("ready while busy");
endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import btec_pkg::*;

  // One input transaction.
  typedef struct packed {
    logic        fn;
    logic [15:0] id;
    logic [7:0]  tag;
    logic [31:0] addr;
    logic [31:0] uuid;
    logic [31:0] base;
    logic [31:0] size;
    logic        ro;
  } bounds_req_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tag;
    logic [31:0] addr;
    logic [31:0] uuid;
    logic [15:0] id;
    logic [31:0] base;
    logic [31:0] size;
    logic        ro;
    logic        fin;
  } bounds_res_t;

  // Directed rows carry a typed result kind where it is obvious.
  localparam int ChkPredictor = -2;
  localparam int ChkSilent = -1;
  localparam int DrainCycles = 60;
  localparam int StallLimit = 3000;

  typedef struct {
    bounds_req_t req;
    int          want;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_CAPACITY;
  logic [4:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = FUNC_LOOKUP;
  logic [15:0] buf_id = '0;
  logic [7:0]  req_tag = '0;
  logic [31:0] acc_addr = '0;
  logic [31:0] req_uuid = '0;
  logic [31:0] fill_base = '0;
  logic [31:0] fill_size = '0;
  logic        fill_ro = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  result_kind;
  logic [7:0]  out_tag;
  logic [31:0] out_addr;
  logic [31:0] out_uuid;
  logic [15:0] out_buf_id;
  logic [31:0] entry_base;
  logic [31:0] entry_size;
  logic        entry_ro;
  logic        last;

  bounds_table_entry_cache_unit dut (.*);

  always #5 clk = ~clk;

  // Shadow copy of the cache, the parked requests and the registers.
  entry_t      cached[$];
  pend_t       parked[$];
  int unsigned cap_reg;
  logic        lru_reg;
  bounds_res_t pending_results[$];

  int  errors = 0;
  int  sent = 0;
  int  received = 0;
  int  idle_count = 0;
  bit  calm = 1'b0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic bounds_res_t make_res(logic [1:0] kind, pend_t p, entry_t e, logic fin);
    bounds_res_t r;
    r.kind = kind;
    r.tag = p.tag;
    r.addr = p.addr;
    r.uuid = p.uuid;
    r.id = p.id;
    r.base = e.base;
    r.size = e.size;
    r.ro = e.ro;
    r.fin = fin;
    return r;
  endfunction

  // Advance the shadow state by one accepted request; returns the results it causes.
  function automatic void cache_update(input bounds_req_t q, output bounds_res_t res[$]);
    pend_t       p;
    entry_t      e;
    entry_t      none;
    int unsigned cap;
    int          i;
    bit          dup;
    res = {};
    none = '0;
    p.id = q.id;
    p.tag = q.tag;
    p.addr = q.addr;
    p.uuid = q.uuid;
    if (q.fn == FUNC_LOOKUP) begin
      for (i = 0; i < cached.size(); i++) begin
        if (cached[i].id == q.id) begin
          e = cached[i];
          res.insert(res.size(), make_res(KIND_ANSWER, p, e, 1'b1));
          if (lru_reg) begin
            cached.delete(i);
            cached.insert(cached.size(), e);
          end
          return;
        end
      end
      if (parked.size() >= DefPendingDepth) begin
        res.insert(res.size(), make_res(KIND_OVERFLOW, p, none, 1'b1));
        return;
      end
      dup = 1'b0;
      foreach (parked[k]) if (parked[k].id == q.id) dup = 1'b1;
      parked.insert(parked.size(), p);
      if (!dup) res.insert(res.size(), make_res(KIND_FETCH, p, none, 1'b1));
    end else begin
      cap = (cap_reg == 0) ? 1 : (cap_reg > DefEntries) ? DefEntries : cap_reg;
      while (cached.size() >= cap) cached.delete(0);
      e.id = q.id;
      e.base = q.base;
      e.size = q.size;
      e.ro = q.ro;
      cached.insert(cached.size(), e);
      i = 0;
      while (i < parked.size() && res.size() < MaxResults) begin
        if (parked[i].id == q.id) begin
          res.insert(res.size(), make_res(KIND_ANSWER, parked[i], e, 1'b0));
          parked.delete(i);
        end else begin
          i++;
        end
      end
      if (res.size() > 0) res[res.size() - 1].fin = 1'b1;
    end
  endfunction

  // Drive one request and hold it until the handshake completes.
  task automatic send(input bounds_req_t q, input int want);
    bounds_res_t res[$];
    in_valid <= 1'b1;
    func <= q.fn;
    buf_id <= q.id;
    req_tag <= q.tag;
    acc_addr <= q.addr;
    req_uuid <= q.uuid;
    fill_base <= q.base;
    fill_size <= q.size;
    fill_ro <= q.ro;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cache_update(q, res);
    sent++;
    if (want == ChkSilent && res.size() != 0) report("result count", 64'(res.size()), 64'(0));
    if (want >= 0) begin
      if (res.size() == 0) report("result count", 64'(0), 64'(1));
      else if (res[0].kind != want) report("table kind", 64'(res[0].kind), 64'(want));
    end
    foreach (res[k]) pending_results.insert(pending_results.size(), res[k]);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_config(input int unsigned cap, input logic lru);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_CAPACITY;
    cfg_data <= cap[4:0];
    @(posedge clk);
    cfg_index <= REG_LRU;
    cfg_data <= {4'b0, lru};
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_reg = cap;
    lru_reg = lru;
  endtask

  function automatic bounds_req_t rand_req(logic fn, logic [15:0] id);
    bounds_req_t q;
    q.fn = fn;
    q.id = id;
    q.tag = 8'($urandom_range(0, 255));
    q.addr = $urandom;
    q.uuid = $urandom;
    q.base = $urandom;
    q.size = $urandom;
    q.ro = 1'($urandom_range(0, 1));
    return q;
  endfunction

  // Random traffic over a small id pool so that hits, merges and fills meet.
  task automatic random_phase(input int count);
    logic [15:0] pool[6];
    logic [15:0] id;
    int          n;
    int          r;
    foreach (pool[k]) pool[k] = 16'($urandom_range(0, 65535));
    n = 0;
    while (n < count) begin
      r = int'($urandom_range(0, 99));
      id = pool[$urandom_range(0, 5)];
      if (r < 6) begin
        // Storm of lookups on one id, enough to overrun the pending table on a miss, then one fill for it.
        repeat (DefPendingDepth + 2) send(rand_req(FUNC_LOOKUP, id), ChkPredictor);
        send(rand_req(FUNC_FILL, id), ChkPredictor);
        n += DefPendingDepth + 3;
      end else begin
        if (r < 60) send(rand_req(FUNC_LOOKUP, id), ChkPredictor);
        else if (r < 66) begin
          send(rand_req(FUNC_LOOKUP, 16'($urandom_range(0, 65535))), ChkPredictor);
        end
        else if (r < 96) send(rand_req(FUNC_FILL, id), ChkPredictor);
        else send(rand_req(FUNC_FILL, 16'($urandom_range(0, 65535))), ChkPredictor);
        n++;
      end
    end
  endtask

  // Result checker.
  always @(posedge clk) begin
    bounds_res_t w;
    if (out_valid && out_ready) begin
      received++;
      if (pending_results.size() == 0) begin
        report("unexpected result kind", 64'(result_kind), 64'(0));
      end else begin
        w = pending_results[0];
        pending_results.delete(0);
        if (result_kind !== w.kind) report("result_kind", 64'(result_kind), 64'(w.kind));
        if (out_tag !== w.tag) report("out_tag", 64'(out_tag), 64'(w.tag));
        if (out_addr !== w.addr) report("out_addr", 64'(out_addr), 64'(w.addr));
        if (out_uuid !== w.uuid) report("out_uuid", 64'(out_uuid), 64'(w.uuid));
        if (out_buf_id !== w.id) report("out_buf_id", 64'(out_buf_id), 64'(w.id));
        if (entry_base !== w.base) report("entry_base", 64'(entry_base), 64'(w.base));
        if (entry_size !== w.size) report("entry_size", 64'(entry_size), 64'(w.size));
        if (entry_ro !== w.ro) report("entry_ro", 64'(entry_ro), 64'(w.ro));
        if (last !== w.fin) report("last", 64'(last), 64'(w.fin));
      end
    end
  end

  // Receiver stalls in random bursts, none during the calm tail.
  always @(posedge clk) begin
    if (calm || $urandom_range(0, 3) != 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      repeat ($urandom_range(0, 4)) @(posedge clk);
    end
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= StallLimit) begin
      $display("Timeout: no transaction for %0d cycles", StallLimit);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    directed_row_t rows[$];
    rows = '{
      '{'{FUNC_LOOKUP, 16'h0000, 8'h00, 32'h0, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1},
        int'(KIND_FETCH)},
      '{'{FUNC_LOOKUP, 16'h0000, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 32'h0, 1'b0},
        ChkSilent},
      '{'{FUNC_FILL, 16'h0000, 8'hA5, 32'h1, 32'h2, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1},
        int'(KIND_ANSWER)},
      '{'{FUNC_LOOKUP, 16'h0000, 8'h11, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0, 1'b0},
        int'(KIND_ANSWER)},
      '{'{FUNC_FILL, 16'hFFFF, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0}, ChkSilent},
      '{'{FUNC_LOOKUP, 16'hFFFF, 8'h22, 32'h12345678, 32'h9ABCDEF0, 32'h5, 32'h6, 1'b1},
        int'(KIND_ANSWER)},
      '{'{FUNC_FILL, 16'h0000, 8'h00, 32'h0, 32'h0, 32'h00001234, 32'h00000040, 1'b0},
        ChkSilent},
      '{'{FUNC_LOOKUP, 16'h0000, 8'h33, 32'h0, 32'h1, 32'h0, 32'h0, 1'b0}, ChkPredictor},
      '{'{FUNC_LOOKUP, 16'h0005, 8'h44, 32'hDEADBEEF, 32'h2, 32'hFFFFFFFF, 32'h3, 1'b1},
        int'(KIND_FETCH)},
      '{'{FUNC_LOOKUP, 16'h0005, 8'h45, 32'h4, 32'h5, 32'h0, 32'h0, 1'b0}, ChkSilent},
      '{'{FUNC_LOOKUP, 16'h0006, 8'h46, 32'h6, 32'h7, 32'h0, 32'h0, 1'b0},
        int'(KIND_FETCH)},
      '{'{FUNC_FILL, 16'h0006, 8'h00, 32'h0, 32'h0, 32'hCAFE0000, 32'h100, 1'b1},
        int'(KIND_ANSWER)},
      '{'{FUNC_FILL, 16'h0005, 8'h00, 32'h0, 32'h0, 32'hBEEF0000, 32'h200, 1'b0},
        ChkPredictor},
      '{'{FUNC_LOOKUP, 16'h0005, 8'h47, 32'h8, 32'h9, 32'h0, 32'h0, 1'b0}, ChkPredictor}
    };
    cap_reg = DefEntries;
    lru_reg = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed rows with reset configuration.
    foreach (rows[k]) send(rows[k].req, rows[k].want);
    random_phase(60);

    // Configuration sweep: smallest, zero, saturating, mid and full values.
    settle();
    write_config(1, 1'b1);
    random_phase(60);
    settle();
    write_config(0, 1'b0);
    random_phase(50);
    settle();
    write_config(31, 1'b1);
    random_phase(70);
    settle();
    write_config(3, 1'b1);
    random_phase(60);
    settle();
    write_config(16, 1'b0);
    random_phase(40);
    calm = 1'b1;
    random_phase(50);

    settle();
    $display("Sent %0d requests, checked %0d results over six capacity/LRU settings.",
             sent, received);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/btec_pkg.sv
rtl/core/btec_entry_cell.sv
rtl/core/btec_pend_cell.sv
rtl/core/bounds_table_entry_cache_unit.sv
sim/tb.sv
